// File: hw/rtl/itp_pkg.sv
package itp_pkg;

    // Stack depth used when the top level is not given one
    localparam int STACK_DEPTH_DEF = 16;

    // ASCII characters the converter reacts to
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Code held in one stack cell
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_OPEN = 3'd5
    } t_op_code;

    // Error reported on every result of an item
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } t_err;

    // Map an arithmetic operator character to its stack code
    function automatic t_op_code f_op_code(input logic [7:0] ch);
        t_op_code code;
        case (ch)
            CH_PLUS:  code = OP_ADD;
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            default:  code = OP_NONE;
        endcase
        return code;
    endfunction

    // Precedence: an open parenthesis on the stack ranks lowest
    function automatic logic [1:0] f_prec(input t_op_code code);
        logic [1:0] prec;
        case (code)
            OP_ADD, OP_SUB: prec = 2'd1;
            OP_MUL, OP_DIV: prec = 2'd2;
            default:        prec = 2'd0;
        endcase
        return prec;
    endfunction

    // Character emitted when a stack code is popped
    function automatic logic [7:0] f_code_char(input t_op_code code);
        logic [7:0] ch;
        case (code)
            OP_ADD:  ch = CH_PLUS;
            OP_SUB:  ch = CH_MINUS;
            OP_MUL:  ch = CH_STAR;
            OP_DIV:  ch = CH_SLASH;
            OP_OPEN: ch = CH_OPEN;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/itp_if.sv
// Input channel: one infix character per item
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       expr_end;

    modport source (output valid, output symbol, output expr_end, input ready);
    modport sink   (input valid, input symbol, input expr_end, output ready);
endinterface

// Output channel: one postfix result per item
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       last_of_expr;
    logic [1:0] error_code;

    modport source (output valid, output out_symbol, output has_symbol,
                    output last_of_expr, output error_code, input ready);
    modport sink   (input valid, input out_symbol, input has_symbol,
                    input last_of_expr, input error_code, output ready);
endinterface

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// An accepted item is registered and worked in the next cycle; its first result is then
// registered into the output register, once that register is free.
// A new item is taken only in the idle state, after the last one has popped its operators
// from the cell chain; the end of an expression also flushes every stacked entry first.
// Reset clears the sequencer, stack count and output valid; cell contents are left as found.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_in,
    itp_out_if.source o_out
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        K_DIGIT,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_OTHER
    } t_kind;

    t_state   r_state, n_state;
    t_kind    r_kind;
    t_op_code r_code;
    logic [7:0] r_sym;
    logic     r_end;
    t_err     r_err;
    logic     r_any;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_open_cnt, n_open_cnt;

    logic       r_ovalid;
    logic [7:0] r_osym;
    logic       r_ohas;
    logic       r_olast;
    t_err       r_oerr;

    t_op_code w_code [STACK_DEPTH];

    // Decode of the incoming character
    t_kind    in_kind;
    t_op_code in_code;
    t_err     in_err;
    logic     accept;

    // Step controls
    logic       emit, e_has, e_last, go, can_emit;
    logic [7:0] e_sym;
    logic       push, pop, inc_open, dec_open;

    t_op_code top, below;
    logic     nonempty, one, two, full;

    assign top      = w_code[0];
    assign below    = w_code[1];
    assign nonempty = (r_count != '0);
    assign one      = (r_count == CW'(1));
    assign two      = (r_count == CW'(2));
    assign full     = (r_count == CW'(STACK_DEPTH));

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign can_emit   = !r_ovalid || o_out.ready;

    // Classify the character and settle its error before any pop
    always_comb begin
        in_code = f_op_code(i_in.symbol);
        in_err  = ERR_NONE;
        if (i_in.symbol >= CH_ZERO && i_in.symbol <= CH_NINE) begin
            in_kind = K_DIGIT;
        end else if (i_in.symbol == CH_OPEN) begin
            in_kind = K_OPEN;
            in_code = OP_OPEN;
            if (full) begin
                in_err = ERR_OVERFLOW;
            end
        end else if (i_in.symbol == CH_CLOSE) begin
            in_kind = K_CLOSE;
            if (r_open_cnt == '0) begin
                in_err = ERR_UNMATCHED;
            end
        end else if (in_code != OP_NONE) begin
            in_kind = K_OPER;
            if (full && (f_prec(in_code) > f_prec(top))) begin
                in_err = ERR_OVERFLOW;
            end
        end else begin
            in_kind = K_OTHER;
        end
    end

    // One step of the sequencer: at most one result and one stack move
    always_comb begin
        emit     = 1'b0;
        e_sym    = 8'h00;
        e_has    = 1'b0;
        e_last   = 1'b0;
        push     = 1'b0;
        pop      = 1'b0;
        inc_open = 1'b0;
        dec_open = 1'b0;
        n_state  = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    K_DIGIT: begin
                        emit    = 1'b1;
                        e_sym   = r_sym;
                        e_has   = 1'b1;
                        e_last  = r_end && !nonempty;
                        n_state = (r_end && nonempty) ? S_FLUSH : S_IDLE;
                    end
                    K_OPEN: begin
                        push     = !full;
                        inc_open = !full;
                        if (r_end) begin
                            n_state = S_FLUSH;
                        end else begin
                            emit    = (r_err != ERR_NONE);
                            n_state = S_IDLE;
                        end
                    end
                    K_CLOSE: begin
                        if (nonempty && top != OP_OPEN) begin
                            emit   = 1'b1;
                            e_sym  = f_code_char(top);
                            e_has  = 1'b1;
                            e_last = r_end && (one || (two && below == OP_OPEN));
                            pop    = 1'b1;
                        end else begin
                            // drop the matching parenthesis
                            pop      = nonempty;
                            dec_open = nonempty;
                            if (r_end && nonempty && !one) begin
                                n_state = S_FLUSH;
                            end else begin
                                emit    = !r_any && (r_end || r_err != ERR_NONE);
                                e_last  = r_end;
                                n_state = S_IDLE;
                            end
                        end
                    end
                    K_OPER: begin
                        if (nonempty && f_prec(r_code) <= f_prec(top)) begin
                            emit  = 1'b1;
                            e_sym = f_code_char(top);
                            e_has = 1'b1;
                            pop   = 1'b1;
                        end else begin
                            push    = !full;
                            emit    = !r_end && (r_err != ERR_NONE);
                            n_state = r_end ? S_FLUSH : S_IDLE;
                        end
                    end
                    default: begin
                        if (r_end && nonempty) begin
                            n_state = S_FLUSH;
                        end else begin
                            emit    = r_end;
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                emit     = 1'b1;
                e_sym    = f_code_char(top);
                e_has    = 1'b1;
                e_last   = one;
                pop      = 1'b1;
                dec_open = (top == OP_OPEN);
                n_state  = one ? S_IDLE : S_FLUSH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the whole step while a result cannot be placed
    assign go = !emit || can_emit;

    always_comb begin
        n_count    = r_count;
        n_open_cnt = r_open_cnt;
        if (go && push) begin
            n_count = r_count + CW'(1);
        end else if (go && pop) begin
            n_count = r_count - CW'(1);
        end
        if (go && inc_open) begin
            n_open_cnt = r_open_cnt + CW'(1);
        end else if (go && dec_open) begin
            n_open_cnt = r_open_cnt - CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_open_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (go) begin
                r_state <= n_state;
            end
            r_count    <= n_count;
            r_open_cnt <= n_open_cnt;
            if (go && emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Capture the item and track whether it has produced a result yet
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= in_kind;
            r_code <= in_code;
            r_sym  <= i_in.symbol;
            r_end  <= i_in.expr_end;
            r_err  <= in_err;
            r_any  <= 1'b0;
        end else if (go && emit) begin
            r_any <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_osym  <= e_sym;
            r_ohas  <= e_has;
            r_olast <= e_last;
            r_oerr  <= r_err;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.out_symbol   = r_osym;
    assign o_out.has_symbol   = r_ohas;
    assign o_out.last_of_expr = r_olast;
    assign o_out.error_code   = r_oerr;

    // Operator stack: chain of cells, top at index 0
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        t_op_code above_code, below_code;
        if (i == 0) begin : g_top
            assign above_code = r_code;
        end else begin : g_mid
            assign above_code = w_code[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bot
            assign below_code = OP_NONE;
        end else begin : g_up
            assign below_code = w_code[i+1];
        end
        itp_cell u_cell (
            .i_clk        (i_clk),
            .i_push       (go && push),
            .i_pop        (go && pop),
            .i_from_above (above_code),
            .i_from_below (below_code),
            .o_code       (w_code[i])
        );
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_cnt <= r_count)
        else $error("open parenthesis count beyond stack count");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH |-> r_count != '0)
        else $error("flush with empty stack");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("accepted item not worked");
`endif

endmodule

// File: hw/rtl/itp_cell.sv
module itp_cell (
    input  logic               i_clk,
    input  logic               i_push,
    input  logic               i_pop,
    input  itp_pkg::t_op_code  i_from_above,
    input  itp_pkg::t_op_code  i_from_below,
    output itp_pkg::t_op_code  o_code
);
    import itp_pkg::*;

    t_op_code r_code;
    t_op_code n_code;

    // Shift down on a push, up on a pop, else hold
    always_comb begin
        n_code = r_code;
        if (i_push) begin
            n_code = i_from_above;
        end else if (i_pop) begin
            n_code = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule
